>>> rtl/core/smt_pkg.sv
package smt_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

>>> rtl/core/smt_ram.sv
module smt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sorted_multiset_table.sv
// Ascending multiset of signed 32-bit values kept in one single-port-read table RAM.
// Each beat is handled on its own: a read of one entry and its processing alternate.
// An insert walks down from the top entry, moving each stored entry greater than or
// equal to the value up one place, and an insert into a full table gets a full status.
// A delete reads every stored entry, and a dump reads every stored entry or, for an
// empty table, gives only its final result. Holding m_ready low on the result side
// stalls the block while a result waits to be taken.
// Op code 3 is accepted and gives no result.
// The next beat is accepted as soon as the last result sits in the output register.
module sorted_multiset_table
    import smt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  value_t                 s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic [COUNT_OUT_W-1:0] m_entry_count,
    output logic                   m_value_valid,
    output value_t                 m_out_value,
    output logic                   m_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_RESP,
        S_DLAST
    } state_t;

    state_t                 state_reg;
    logic [OP_W-1:0]        op_reg;
    value_t                 val_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          ptr_reg;
    logic                   found_reg;
    logic                   have_pend_reg;
    value_t                 pend_reg;
    logic [STATUS_W-1:0]    resp_status_reg;

    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [COUNT_OUT_W-1:0] m_entry_count_reg;
    logic                   m_value_valid_reg;
    value_t                 m_out_value_reg;
    logic                   m_last_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_W-1:0]     ram_rdata;
    value_t                 rd_val;
    logic [CW-1:0]          ptr_m1;
    logic [CW-1:0]          count_inc;
    logic [CW+COUNT_OUT_W-1:0] count_ext;
    logic                   out_free;
    logic                   emit;

    assign rd_val    = value_t'(ram_rdata);
    assign ptr_m1    = ptr_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = out_free &&
                       ((state_reg == S_RESP) || (state_reg == S_DLAST) ||
                        (state_reg == S_PROC && op_reg == OP_DUMP &&
                         have_pend_reg && rd_val != pend_reg));

    smt_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[AW-1:0];
        unique case (state_reg)
            S_READ: begin
                if (op_reg == OP_INSERT) begin
                    if (ptr_reg == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = val_reg;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_m1[AW-1:0];
                    end
                end else if (ptr_reg != count_reg) begin
                    ram_re = 1'b1;
                end
            end
            S_PROC: begin
                if (op_reg == OP_INSERT) begin
                    ram_we = 1'b1;
                    if (rd_val < val_reg) begin
                        ram_wdata = val_reg;
                    end
                end else if (op_reg == OP_DELETE && found_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_m1[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_pend_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg        <= s_operation;
                        val_reg       <= s_value;
                        found_reg     <= 1'b0;
                        have_pend_reg <= 1'b0;
                        if (s_operation == OP_INSERT) begin
                            ptr_reg <= count_reg;
                            if (count_reg >= DEPTH_C) begin
                                resp_status_reg <= ST_FULL;
                                state_reg       <= S_RESP;
                            end else begin
                                state_reg <= S_READ;
                            end
                        end else if (s_operation == OP_DELETE) begin
                            ptr_reg   <= '0;
                            state_reg <= S_READ;
                        end else if (s_operation == OP_DUMP) begin
                            ptr_reg <= '0;
                            if (count_reg == '0) begin
                                resp_status_reg <= ST_DONE;
                                state_reg       <= S_RESP;
                            end else begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    if (op_reg == OP_INSERT) begin
                        if (ptr_reg == '0) begin
                            count_reg       <= count_inc;
                            resp_status_reg <= ST_DONE;
                            state_reg       <= S_RESP;
                        end else begin
                            state_reg <= S_PROC;
                        end
                    end else if (ptr_reg == count_reg) begin
                        if (op_reg == OP_DELETE) begin
                            if (found_reg) begin
                                count_reg       <= count_reg - 1'b1;
                                resp_status_reg <= ST_DONE;
                            end else begin
                                resp_status_reg <= ST_NOT_FOUND;
                            end
                            state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_DLAST;
                        end
                    end else begin
                        state_reg <= S_PROC;
                    end
                end
                S_PROC: begin
                    if (op_reg == OP_INSERT) begin
                        if (rd_val < val_reg) begin
                            count_reg       <= count_inc;
                            resp_status_reg <= ST_DONE;
                            state_reg       <= S_RESP;
                        end else begin
                            ptr_reg   <= ptr_m1;
                            state_reg <= S_READ;
                        end
                    end else if (op_reg == OP_DELETE) begin
                        if (!found_reg && rd_val == val_reg) begin
                            found_reg <= 1'b1;
                        end
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_READ;
                    end else if (have_pend_reg && rd_val != pend_reg) begin
                        if (out_free) begin
                            m_valid_reg       <= 1'b1;
                            m_status_reg      <= ST_DONE;
                            m_entry_count_reg <= count_ext[COUNT_OUT_W-1:0];
                            m_value_valid_reg <= 1'b1;
                            m_out_value_reg   <= pend_reg;
                            m_last_reg        <= 1'b0;
                            pend_reg          <= rd_val;
                            ptr_reg           <= ptr_reg + 1'b1;
                            state_reg         <= S_READ;
                        end
                    end else begin
                        pend_reg      <= rd_val;
                        have_pend_reg <= 1'b1;
                        ptr_reg       <= ptr_reg + 1'b1;
                        state_reg     <= S_READ;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= resp_status_reg;
                        m_entry_count_reg <= count_ext[COUNT_OUT_W-1:0];
                        m_value_valid_reg <= 1'b0;
                        m_out_value_reg   <= '0;
                        m_last_reg        <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                S_DLAST: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= ST_DONE;
                        m_entry_count_reg <= count_ext[COUNT_OUT_W-1:0];
                        m_value_valid_reg <= 1'b1;
                        m_out_value_reg   <= pend_reg;
                        m_last_reg        <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign count_ext     = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_value_valid = m_value_valid_reg;
    assign m_out_value   = m_out_value_reg;
    assign m_last        = m_last_reg;

endmodule
